// ===== hdl/esc_pkg.sv =====
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types, tables and elaboration-time functions for the epoch seconds
// to calendar converter.
// ----------------------------------------------------------------------------
package esc_pkg;

	localparam int YS_DEPTH = 256;

	typedef logic [16:0] ys_word_t;
	typedef ys_word_t ys_tab_t [YS_DEPTH];

	// cumulative days before month, row 1 for leap years
	localparam logic [8:0] DBM [2][13] = '{
		'{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181, 9'd212, 9'd243,
		  9'd273, 9'd304, 9'd334, 9'd365},
		'{9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182, 9'd213, 9'd244,
		  9'd274, 9'd305, 9'd335, 9'd366}
	};

	function automatic bit is_leap(int y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	// day offset of Jan 1 of each year from the base year on
	function automatic ys_tab_t year_starts(int base);
		ys_tab_t t;
		int acc;
		acc = 0;
		for (int i = 0; i < YS_DEPTH; i++) begin
			t[i] = ys_word_t'(acc);
			acc = acc + (is_leap(base + i) ? 366 : 365);
		end
		return t;
	endfunction

	// weekday of Jan 1 of the base year, 0 = Monday
	function automatic logic [2:0] jan1_weekday(int base);
		int y;
		int s;
		y = base - 1;
		s = 1 + 26 + 8 + y + y / 4 + y / 400 - y / 100;
		return 3'(s % 7);
	endfunction

endpackage

// ===== hdl/esc_if.sv =====
// ----------------------------------------------------------------------------
// esc_in_if / esc_out_if
// Valid/ready channels for the seconds input and the calendar result.
// ----------------------------------------------------------------------------
interface esc_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] elapsed_seconds;
	modport source (output valid, output elapsed_seconds, input ready);
	modport sink   (input valid, input elapsed_seconds, output ready);
endinterface

interface esc_out_if;
	logic        valid;
	logic        ready;
	logic [11:0] year;
	logic [3:0]  month;
	logic [4:0]  day_of_month;
	logic [4:0]  hour;
	logic [5:0]  minute;
	logic [5:0]  second_of_minute;
	logic [2:0]  weekday;
	modport source (output valid, output year, output month, output day_of_month,
		output hour, output minute, output second_of_minute, output weekday,
		input ready);
	modport sink   (input valid, input year, input month, input day_of_month,
		input hour, input minute, input second_of_minute, input weekday,
		output ready);
endinterface

// ===== hdl/esc_time.sv =====
// ----------------------------------------------------------------------------
// esc_time
// Time-of-day split into hour, minute and second over stages 3 to 6.
// ----------------------------------------------------------------------------
module esc_time import esc_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [16:0] tod,
	output logic [4:0]  hour,
	output logic [5:0]  minute,
	output logic [5:0]  second_of_minute
);
	// tod / 3600 = (tod * 149131) >> 29, exact below 2^17
	logic [34:0] hprod_s3;
	logic [16:0] tod_s3;
	logic [4:0]  hour_s4;
	logic [11:0] rem_s4;
	logic [24:0] mprod_s5;
	logic [11:0] rem_s5;
	logic [4:0]  hour_s5;
	logic [5:0]  hour_w;
	logic [6:0]  min_w;

	assign hour_w = hprod_s3[34:29];
	assign min_w  = mprod_s5[24:18];

	always_ff @(posedge clk) begin
		if (en) begin
			hprod_s3 <= 35'(tod) * 35'd149131;
			tod_s3   <= tod;
			hour_s4  <= hour_w[4:0];
			rem_s4   <= 12'(tod_s3 - 17'(hour_w * 17'd3600));
			// rem / 60 = (rem * 4370) >> 18, exact below 2^12
			mprod_s5 <= 25'(rem_s4) * 25'd4370;
			rem_s5   <= rem_s4;
			hour_s5  <= hour_s4;
			hour             <= hour_s5;
			minute           <= min_w[5:0];
			second_of_minute <= 6'(rem_s5 - 12'(min_w * 12'd60));
		end
	end
endmodule

// ===== hdl/esc_date.sv =====
// ----------------------------------------------------------------------------
// esc_date
// Day count to year, month, day and weekday over stages 3 to 6.
// ----------------------------------------------------------------------------
module esc_date import esc_pkg::*; #(
	parameter int BASE_YEAR = 2000
) (
	input  logic        clk,
	input  logic        en,
	input  logic [15:0] days,
	output logic [11:0] year,
	output logic [3:0]  month,
	output logic [4:0]  day_of_month,
	output logic [2:0]  weekday
);
	localparam ys_tab_t    YS  = year_starts(BASE_YEAR);
	localparam logic [2:0] WD0 = jan1_weekday(BASE_YEAR);

	logic [32:0] eprod_s3;
	logic [32:0] q7prod_s3;
	logic [15:0] days_s3;
	logic [7:0]  yoff_s4;
	logic [11:0] year_s4;
	logic [2:0]  r7_s4;
	logic [15:0] days_s4;
	logic [8:0]  doy_s5;
	logic        leap_s5;
	logic [11:0] year_s5;
	logic [2:0]  wd_s5;

	logic [7:0]  est_w;
	logic [7:0]  yoff_w;
	logic [13:0] q7_w;
	logic [3:0]  wsum_w;
	logic [16:0] ylen_w;
	logic [3:0]  m_w;

	// floor(days / 366) is the true year offset or one short of it
	assign est_w  = eprod_s3[32:25];
	assign yoff_w = est_w + 8'((17'(days_s3) >= YS[est_w + 8'd1]) ? 1 : 0);
	assign q7_w   = q7prod_s3[32:19];
	assign wsum_w = 4'(r7_s4) + 4'(WD0);
	assign ylen_w = YS[yoff_s4 + 8'd1] - YS[yoff_s4];

	always_comb begin
		m_w = 4'd12;
		for (int i = 12; i >= 1; i--) begin
			if (doy_s5 < DBM[leap_s5][i]) m_w = 4'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			eprod_s3  <= 33'(days) * 33'd91679;
			q7prod_s3 <= 33'(days) * 33'd74899;
			days_s3   <= days;
			yoff_s4   <= yoff_w;
			year_s4   <= 12'(BASE_YEAR) + 12'(yoff_w);
			r7_s4     <= 3'(days_s3 - 16'(q7_w * 16'd7));
			days_s4   <= days_s3;
			doy_s5    <= 9'(17'(days_s4) - YS[yoff_s4]);
			leap_s5   <= (ylen_w == 17'd366);
			year_s5   <= year_s4;
			wd_s5     <= (wsum_w >= 4'd7) ? 3'(wsum_w - 4'd7) : wsum_w[2:0];
			year         <= year_s5;
			month        <= m_w;
			day_of_month <= 5'(doy_s5 - DBM[leap_s5][m_w - 4'd1] + 9'd1);
			weekday      <= wd_s5 + 3'd1;
		end
	end
endmodule

// ===== hdl/epoch_seconds_to_calendar.sv =====
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// Seconds since Jan 1 of BASE_YEAR to Gregorian date, time and weekday.
// ----------------------------------------------------------------------------
// channel  dir  payload
// in_ch    in   elapsed_seconds[31:0]
// out_ch   out  year, month, day_of_month, hour, minute, second_of_minute,
//               weekday
//
// Six-stage pipeline, one transaction per cycle unless out_ch stalls; the
// depth is set by the chained reciprocal multiplies (divide by 86400, then
// 3600 and 60) and the year table lookups.
// A stall at out_ch freezes every stage at once; nothing is lost or repeated.
// Reset clears only the stage valid bits.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar import esc_pkg::*; #(
	parameter int BASE_YEAR = 2000
) (
	input  logic       clk,
	input  logic       arst_n,
	esc_in_if.sink     in_ch,
	esc_out_if.source  out_ch
);
	logic [6:1]  vld_q;
	logic        adv;
	logic [50:0] prod_s1;
	logic [24:0] s7_s1;
	logic [6:0]  lo_s1;
	logic [15:0] days_s2;
	logic [16:0] tod_s2;
	logic [15:0] days_w;
	logic [24:0] rem7_w;

	assign adv         = !vld_q[6] || out_ch.ready;
	assign in_ch.ready = adv;
	assign out_ch.valid = vld_q[6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[5:1], in_ch.valid};
		end
	end

	// secs / 86400 = (secs >> 7) / 675, reciprocal 50903317 >> 35
	assign days_w = prod_s1[50:35];
	assign rem7_w = s7_s1 - 25'(days_w * 25'd675);

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1 <= 51'(in_ch.elapsed_seconds[31:7]) * 51'd50903317;
			s7_s1   <= in_ch.elapsed_seconds[31:7];
			lo_s1   <= in_ch.elapsed_seconds[6:0];
			days_s2 <= days_w;
			tod_s2  <= {rem7_w[9:0], lo_s1};
		end
	end

	esc_time u_time (
		.clk              (clk),
		.en               (adv),
		.tod              (tod_s2),
		.hour             (out_ch.hour),
		.minute           (out_ch.minute),
		.second_of_minute (out_ch.second_of_minute)
	);

	esc_date #(.BASE_YEAR(BASE_YEAR)) u_date (
		.clk          (clk),
		.en           (adv),
		.days         (days_s2),
		.year         (out_ch.year),
		.month        (out_ch.month),
		.day_of_month (out_ch.day_of_month),
		.weekday      (out_ch.weekday)
	);

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> vld_q[1])
		else $error("accepted transaction did not enter stage 1");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_q))
		else $error("pipeline moved during stall");

	a_date: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.month >= 4'd1) && (out_ch.month <= 4'd12) &&
		(out_ch.day_of_month >= 5'd1) && (out_ch.weekday >= 3'd1))
		else $error("calendar field out of range");

	a_time: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.hour < 5'd24) && (out_ch.minute < 6'd60) &&
		(out_ch.second_of_minute < 6'd60))
		else $error("time field out of range");
endmodule
